### hw/rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
// Holds the sequencer state type, request and status codes, and field widths.
// No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

	localparam int MODE_W = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DEL_END   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_LIST      = 3'd6;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OOB   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMIT,
		ST_INS_TAKE,
		ST_INS_FREE,
		ST_WALK,
		ST_WALK_WAIT,
		ST_LINK_RD,
		ST_INS_LINK,
		ST_INS_HOOK,
		ST_DEL_D,
		ST_DEL_UNLINK,
		ST_DEL_FREE,
		ST_LIST_OUT
	} pls_state_t;

endpackage

### hw/rtl/pls_link_mem.sv
// Link memory of the positional list store: one next-slot entry per slot.
// Synchronous write, registered read; per-entry valid bits give the reset chain.
// No package dependencies.
`timescale 1ns / 1ps

module pls_link_mem #(
	parameter int CAPACITY = 32,
	parameter int SW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [SW-1:0] rd_addr,
	output logic [SW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [SW-1:0] wr_addr,
	input  logic [SW-1:0] wr_data
);

	logic [SW-1:0]       link_mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;
	logic [SW-1:0]       rst_link;
	logic [SW-1:0]       rd_data_q;

	// unwritten entry chains to the next slot, the last one wraps to slot 0
	always_comb begin
		if (rd_addr == SW'(CAPACITY - 1)) begin
			rst_link = '0;
		end else begin
			rst_link = rd_addr + SW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			link_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= vld_q[rd_addr] ? link_mem[rd_addr] : rst_link;
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/positional_list_store.sv
// Top level of the positional list store: request sequencer, value memory
// and output register. Depends on pls_pkg and pls_link_mem.
`timescale 1ns / 1ps

// Bounded singly linked list of signed 32-bit values, addressed by 1-based
// position. Each request item inserts (front, end, position), deletes (front,
// end, position) or lists the contents; every request but a listing answers
// with one result item, a listing answers with one item per element (tlast on
// the final one) or one empty item. Slots live in two single-port-style
// memories with a registered read: a value memory and a link memory.
// Unused slots form a free chain. An insert or a delete at a position of 2
// or more walks the link memory one link per cycle from the head to the
// predecessor of that position (end operations use length + 1 or length).
// A new request is accepted when the sequencer is idle, even while the last
// result item still waits in the output register.
module positional_list_store #(
	parameter int CAPACITY = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// mode[2:0], item_value[34:3], position[40:35], zero fill [47:41]
	input  logic [pls_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// status[1:0], result_value[33:2], result_position[39:34],
	// list_length[45:40], zero fill [47:46]
	output logic [pls_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tlast
);

	import pls_pkg::*;

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = ((CW > POS_W) ? CW : POS_W) + 1;

	// sequencer state
	pls_state_t state_q, state_d;
	logic [SW-1:0] head_q, head_d;
	logic [SW-1:0] free_q, free_d;
	logic [CW-1:0] count_q, count_d;

	// per-request working registers
	logic          front_q, front_d;
	logic          is_ins_q, is_ins_d;
	logic [SW-1:0] new_q, new_d;
	logic [SW-1:0] del_q, del_d;
	logic [SW-1:0] cur_q, cur_d;
	logic [CW-1:0] steps_q, steps_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] tgt_q, tgt_d;
	logic [VAL_W-1:0] val_q, val_d;

	// pending single result
	logic [STAT_W-1:0] res_status_q, res_status_d;
	logic [VAL_W-1:0]  res_value_q, res_value_d;
	logic [CW-1:0]     res_pos_q, res_pos_d;
	logic [CW-1:0]     res_len_q, res_len_d;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_value_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [POS_W-1:0]  out_len_q;
	logic              out_last_q;
	logic              out_free;
	logic              out_load;
	logic [STAT_W-1:0] ld_status;
	logic [VAL_W-1:0]  ld_value;
	logic [POS_W-1:0]  ld_pos;
	logic [POS_W-1:0]  ld_len;
	logic              ld_last;

	// memory ports
	logic          lk_re;
	logic [SW-1:0] lk_raddr;
	logic [SW-1:0] link_rd;
	logic          lk_we;
	logic [SW-1:0] lk_waddr;
	logic [SW-1:0] lk_wdata;
	logic          val_re;
	logic [SW-1:0] val_raddr;
	logic          val_we;
	logic [VAL_W-1:0] val_mem [CAPACITY];
	logic [VAL_W-1:0] val_rd_q;

	// request decode
	logic [MODE_W-1:0] in_mode;
	logic [VAL_W-1:0]  in_value;
	logic [POS_W-1:0]  in_pos;
	logic [TW-1:0]     cnt_ext;
	logic [TW-1:0]     ins_tgt;
	logic [TW-1:0]     del_tgt;

	assign in_mode  = s_axis_tdata[MODE_W-1:0];
	assign in_value = s_axis_tdata[MODE_W +: VAL_W];
	assign in_pos   = s_axis_tdata[MODE_W + VAL_W +: POS_W];
	assign cnt_ext  = TW'(count_q);

	always_comb begin
		case (in_mode)
			MODE_INS_FRONT: ins_tgt = TW'(1);
			MODE_INS_END:   ins_tgt = cnt_ext + TW'(1);
			default:        ins_tgt = TW'(in_pos);
		endcase
		case (in_mode)
			MODE_DEL_FRONT: del_tgt = TW'(1);
			MODE_DEL_END:   del_tgt = cnt_ext;
			default:        del_tgt = TW'(in_pos);
		endcase
	end

	assign out_free = !out_valid_q || m_axis_tready;

	pls_link_mem #(
		.CAPACITY (CAPACITY),
		.SW       (SW)
	) u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (lk_re),
		.rd_addr (lk_raddr),
		.rd_data (link_rd),
		.wr_en   (lk_we),
		.wr_addr (lk_waddr),
		.wr_data (lk_wdata)
	);

	// value memory: slots are read only after being written
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[free_q] <= val_q;
		end
		if (val_re) begin
			val_rd_q <= val_mem[val_raddr];
		end
	end

	// sequencer: next state, memory control and result assembly
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		free_d       = free_q;
		count_d      = count_q;
		front_d      = front_q;
		is_ins_d     = is_ins_q;
		new_d        = new_q;
		del_d        = del_q;
		cur_d        = cur_q;
		steps_d      = steps_q;
		idx_d        = idx_q;
		tgt_d        = tgt_q;
		val_d        = val_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		res_pos_d    = res_pos_q;
		res_len_d    = res_len_q;

		out_load  = 1'b0;
		ld_status = STAT_OK;
		ld_value  = '0;
		ld_pos    = '0;
		ld_len    = '0;
		ld_last   = 1'b0;

		lk_re     = 1'b0;
		lk_raddr  = cur_q;
		lk_we     = 1'b0;
		lk_waddr  = cur_q;
		lk_wdata  = new_q;
		val_re    = 1'b0;
		val_raddr = cur_q;
		val_we    = 1'b0;

		s_axis_tready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					val_d        = in_value;
					res_status_d = STAT_OK;
					res_value_d  = '0;
					res_pos_d    = '0;
					res_len_d    = count_q;
					state_d      = ST_EMIT;
					case (in_mode)
						MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
							if (ins_tgt == '0 || ins_tgt > cnt_ext + TW'(1)) begin
								res_status_d = STAT_OOB;
							end else if (count_q == CW'(CAPACITY)) begin
								res_status_d = STAT_FULL;
							end else begin
								is_ins_d = 1'b1;
								tgt_d    = CW'(ins_tgt);
								front_d  = (ins_tgt == TW'(1));
								state_d  = ST_INS_TAKE;
							end
						end
						MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_POS: begin
							if (count_q == '0) begin
								res_status_d = STAT_EMPTY;
							end else if (del_tgt == '0 || del_tgt > cnt_ext) begin
								res_status_d = STAT_OOB;
							end else begin
								is_ins_d = 1'b0;
								tgt_d    = CW'(del_tgt);
								front_d  = (del_tgt == TW'(1));
								cur_d    = head_q;
								steps_d  = CW'(del_tgt - TW'(2));
								state_d  = (del_tgt == TW'(1)) ? ST_DEL_D : ST_WALK;
							end
						end
						MODE_LIST: begin
							if (count_q == '0) begin
								res_status_d = STAT_EMPTY;
							end else begin
								lk_re     = 1'b1;
								lk_raddr  = head_q;
								val_re    = 1'b1;
								val_raddr = head_q;
								idx_d     = '0;
								state_d   = ST_LIST_OUT;
							end
						end
						default: begin
							// unused code: report ok and the current length
						end
					endcase
				end
			end

			ST_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = res_status_q;
					ld_value  = res_value_q;
					ld_pos    = POS_W'(res_pos_q);
					ld_len    = POS_W'(res_len_q);
					ld_last   = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			ST_INS_TAKE: begin
				// pop the free chain head and store the value there
				lk_re    = 1'b1;
				lk_raddr = free_q;
				val_we   = 1'b1;
				new_d    = free_q;
				state_d  = ST_INS_FREE;
			end

			ST_INS_FREE: begin
				free_d = link_rd;
				if (front_q) begin
					lk_we        = 1'b1;
					lk_waddr     = new_q;
					lk_wdata     = head_q;
					head_d       = new_q;
					count_d      = count_q + CW'(1);
					res_len_d    = count_q + CW'(1);
					state_d      = ST_EMIT;
				end else begin
					cur_d   = head_q;
					steps_d = tgt_q - CW'(2);
					state_d = ST_WALK;
				end
			end

			ST_WALK: begin
				if (steps_q == '0) begin
					state_d = ST_LINK_RD;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = cur_q;
					state_d  = ST_WALK_WAIT;
				end
			end

			ST_WALK_WAIT: begin
				// advance one link per cycle, chaining the read data to the next address
				cur_d   = link_rd;
				steps_d = steps_q - CW'(1);
				if (steps_q == CW'(1)) begin
					state_d = ST_LINK_RD;
				end else begin
					lk_re    = 1'b1;
					lk_raddr = link_rd;
				end
			end

			ST_LINK_RD: begin
				// cur_q now holds the predecessor of the target position
				lk_re    = 1'b1;
				lk_raddr = cur_q;
				state_d  = is_ins_q ? ST_INS_LINK : ST_DEL_D;
			end

			ST_INS_LINK: begin
				lk_we    = 1'b1;
				lk_waddr = new_q;
				lk_wdata = link_rd;
				state_d  = ST_INS_HOOK;
			end

			ST_INS_HOOK: begin
				lk_we     = 1'b1;
				lk_waddr  = cur_q;
				lk_wdata  = new_q;
				count_d   = count_q + CW'(1);
				res_len_d = count_q + CW'(1);
				state_d   = ST_EMIT;
			end

			ST_DEL_D: begin
				del_d     = front_q ? head_q : link_rd;
				lk_re     = 1'b1;
				lk_raddr  = front_q ? head_q : link_rd;
				val_re    = 1'b1;
				val_raddr = front_q ? head_q : link_rd;
				state_d   = ST_DEL_UNLINK;
			end

			ST_DEL_UNLINK: begin
				if (front_q) begin
					head_d = link_rd;
				end else begin
					lk_we    = 1'b1;
					lk_waddr = cur_q;
					lk_wdata = link_rd;
				end
				res_value_d = val_rd_q;
				state_d     = ST_DEL_FREE;
			end

			ST_DEL_FREE: begin
				// push the freed slot onto the free chain
				lk_we     = 1'b1;
				lk_waddr  = del_q;
				lk_wdata  = free_q;
				free_d    = del_q;
				count_d   = count_q - CW'(1);
				res_pos_d = tgt_q;
				res_len_d = count_q - CW'(1);
				state_d   = ST_EMIT;
			end

			ST_LIST_OUT: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_status = STAT_OK;
					ld_value  = val_rd_q;
					ld_pos    = POS_W'(idx_q + CW'(1));
					ld_len    = POS_W'(count_q);
					ld_last   = ((idx_q + CW'(1)) == count_q);
					if ((idx_q + CW'(1)) == count_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d     = idx_q + CW'(1);
						lk_re     = 1'b1;
						lk_raddr  = link_rd;
						val_re    = 1'b1;
						val_raddr = link_rd;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			free_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		front_q      <= front_d;
		is_ins_q     <= is_ins_d;
		new_q        <= new_d;
		del_q        <= del_d;
		cur_q        <= cur_d;
		steps_q      <= steps_d;
		idx_q        <= idx_d;
		tgt_q        <= tgt_d;
		val_q        <= val_d;
		res_status_q <= res_status_d;
		res_value_q  <= res_value_d;
		res_pos_q    <= res_pos_d;
		res_len_q    <= res_len_d;
		if (out_load) begin
			out_status_q <= ld_status;
			out_value_q  <= ld_value;
			out_pos_q    <= ld_pos;
			out_len_q    <= ld_len;
			out_last_q   <= ld_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		{(OUT_TDATA_W - STAT_W - VAL_W - 2 * POS_W){1'b0}},
		out_len_q, out_pos_q, out_value_q, out_status_q
	};

endmodule

### bench/positional_list_store_tb.sv
// Self-checking bench for positional_list_store: directed table, then random traffic.
// The list is predicted as a queue of values, and each result item is checked against it.
// Depends on pls_pkg and the positional_list_store RTL.
`timescale 1ns / 1ps

module positional_list_store_tb;
	import pls_pkg::*;

	localparam int LIST_CAPACITY = 32;
	localparam int RANDOM_ITEMS  = 198;
	// 3'd7 has no package name; the block answers it like a no-op.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  position;
		logic [POS_W-1:0]  length;
		logic              last;
	} list_result_t;

	localparam list_result_t NO_RESULT = '0;

	// Row of the directed table. When has_known is set, known holds the one
	// result the row must give; otherwise the list predictor supplies it.
	typedef struct {
		logic [MODE_W-1:0] md;
		logic [VAL_W-1:0]  value;
		logic [POS_W-1:0]  pos;
		bit                has_known;
		list_result_t      known;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// Predicted list contents, head first, and results still owed by the block.
	logic [VAL_W-1:0] stored_values[$];
	list_result_t pending_results[$];
	int error_count = 0;
	bit quiet_stretch = 1'b0;

	directed_row_t directed_rows [22] = '{
		// Empty list: every delete and the listing report empty.
		'{MODE_DEL_FRONT, 32'h0, 6'd0, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 6'd0, 1'b1}},
		'{MODE_DEL_END,   32'h0, 6'd0, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 6'd0, 1'b1}},
		'{MODE_DEL_POS,   32'h0, 6'd5, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 6'd0, 1'b1}},
		'{MODE_LIST,      32'h0, 6'd0, 1'b1, '{STAT_EMPTY, 32'h0, 6'd0, 6'd0, 1'b1}},
		'{MODE_UNUSED,    32'h0, 6'd0, 1'b1, '{STAT_OK,    32'h0, 6'd0, 6'd0, 1'b1}},
		// Insert positions outside 1..length+1.
		'{MODE_INS_POS, 32'h1234_5678, 6'd0, 1'b1, '{STAT_OOB, 32'h0, 6'd0, 6'd0, 1'b1}},
		'{MODE_INS_POS, 32'h1234_5678, 6'd2, 1'b1, '{STAT_OOB, 32'h0, 6'd0, 6'd0, 1'b1}},
		// Value extremes through every insert flavor; position 1 acts as front.
		'{MODE_INS_FRONT, 32'h7FFF_FFFF, 6'd0, 1'b1, '{STAT_OK, 32'h0, 6'd0, 6'd1, 1'b1}},
		'{MODE_INS_END,   32'h8000_0000, 6'd0, 1'b1, '{STAT_OK, 32'h0, 6'd0, 6'd2, 1'b1}},
		'{MODE_INS_POS,   32'hFFFF_FFFF, 6'd1, 1'b1, '{STAT_OK, 32'h0, 6'd0, 6'd3, 1'b1}},
		'{MODE_INS_POS,   32'h0000_0000, 6'd4, 1'b1, '{STAT_OK, 32'h0, 6'd0, 6'd4, 1'b1}},
		'{MODE_INS_POS,   32'hDEAD_BEEF, 6'd63, 1'b1, '{STAT_OOB, 32'h0, 6'd0, 6'd4, 1'b1}},
		'{MODE_LIST,      32'h0, 6'd0, 1'b0, NO_RESULT},
		// Delete positions outside 1..length on a non-empty list.
		'{MODE_DEL_POS, 32'h0, 6'd0, 1'b1, '{STAT_OOB, 32'h0, 6'd0, 6'd4, 1'b1}},
		'{MODE_DEL_POS, 32'h0, 6'd5, 1'b1, '{STAT_OOB, 32'h0, 6'd0, 6'd4, 1'b1}},
		'{MODE_DEL_POS,   32'h0, 6'd2, 1'b0, NO_RESULT},
		'{MODE_DEL_END,   32'h0, 6'd0, 1'b0, NO_RESULT},
		'{MODE_DEL_FRONT, 32'h0, 6'd0, 1'b0, NO_RESULT},
		'{MODE_LIST,      32'h0, 6'd0, 1'b0, NO_RESULT},
		'{MODE_INS_POS,   32'h5A5A_A5A5, 6'd2, 1'b0, NO_RESULT},
		'{MODE_DEL_POS,   32'h0, 6'd1, 1'b0, NO_RESULT},
		'{MODE_UNUSED,    32'hFFFF_FFFF, 6'd63, 1'b0, NO_RESULT}
	};

	positional_list_store #(
		.CAPACITY(LIST_CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("positional_list_store_tb: errors");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	function automatic list_result_t make_result(input logic [STAT_W-1:0] st,
			input logic [VAL_W-1:0] v, input int pos, input int len, input bit lst);
		list_result_t r;
		r.status = st;
		r.value = v;
		r.position = pos[POS_W-1:0];
		r.length = len[POS_W-1:0];
		r.last = lst;
		return r;
	endfunction

	// Apply one accepted request to the predicted list; queue its results
	// when record is set.
	task automatic apply_to_list(input logic [MODE_W-1:0] md, input logic [VAL_W-1:0] v,
			input logic [POS_W-1:0] p, input bit record);
		list_result_t owed[$];
		int count;
		int target;
		logic [VAL_W-1:0] removed;
		count = stored_values.size();
		case (md)
			MODE_INS_FRONT, MODE_INS_END, MODE_INS_POS: begin
				target = (md == MODE_INS_FRONT) ? 1 : (md == MODE_INS_END) ? count + 1 : int'(p);
				if (target < 1 || target > count + 1) begin
					owed.push_back(make_result(STAT_OOB, '0, 0, count, 1'b1));
				end else if (count >= LIST_CAPACITY) begin
					owed.push_back(make_result(STAT_FULL, '0, 0, count, 1'b1));
				end else begin
					stored_values.insert(target - 1, v);
					owed.push_back(make_result(STAT_OK, '0, 0, count + 1, 1'b1));
				end
			end
			MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_POS: begin
				target = (md == MODE_DEL_FRONT) ? 1 : (md == MODE_DEL_END) ? count : int'(p);
				if (count == 0) begin
					owed.push_back(make_result(STAT_EMPTY, '0, 0, 0, 1'b1));
				end else if (target < 1 || target > count) begin
					owed.push_back(make_result(STAT_OOB, '0, 0, count, 1'b1));
				end else begin
					removed = stored_values[target - 1];
					stored_values.delete(target - 1);
					owed.push_back(make_result(STAT_OK, removed, target, count - 1, 1'b1));
				end
			end
			MODE_LIST: begin
				if (count == 0) begin
					owed.push_back(make_result(STAT_EMPTY, '0, 0, 0, 1'b1));
				end else begin
					foreach (stored_values[k]) begin
						owed.push_back(make_result(STAT_OK, stored_values[k], k + 1, count,
							k == count - 1));
					end
				end
			end
			default: begin
				owed.push_back(make_result(STAT_OK, '0, 0, count, 1'b1));
			end
		endcase
		if (record) begin
			foreach (owed[k]) pending_results.push_back(owed[k]);
		end
	endtask

	// Present one request item at the falling edge, hold it until accepted,
	// then book its expected results. Valid stays high into the next call
	// unless that call opens a gap.
	task automatic send_request(input logic [MODE_W-1:0] md, input logic [VAL_W-1:0] v,
			input logic [POS_W-1:0] p, input bit has_known, input list_result_t known);
		@(negedge clk);
		while (!quiet_stretch && $urandom_range(99) < 31) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, p, v, md};
		do @(posedge clk); while (!s_axis_tready);
		if (has_known) begin
			apply_to_list(md, v, p, 1'b0);
			pending_results.push_back(known);
		end else begin
			apply_to_list(md, v, p, 1'b1);
		end
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Result side: stall at random, except during the quiet stretch.
	always @(negedge clk) begin
		m_axis_tready <= quiet_stretch || ($urandom_range(99) >= 31);
	end

	task automatic check_field(input string name, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
		end
	endtask

	// Compare every accepted result item against the oldest expectation.
	always @(posedge clk) begin : watch_results
		list_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				check_field("status", VAL_W'(m_axis_tdata[1:0]), VAL_W'(want.status));
				check_field("value", m_axis_tdata[33:2], want.value);
				check_field("position", VAL_W'(m_axis_tdata[39:34]), VAL_W'(want.position));
				check_field("length", VAL_W'(m_axis_tdata[45:40]), VAL_W'(want.length));
				check_field("tlast", VAL_W'(m_axis_tlast), VAL_W'(want.last));
			end
		end
	end

	initial begin
		int count;
		int roll;
		bit growing;
		logic [MODE_W-1:0] md;
		logic [POS_W-1:0] p;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].md, directed_rows[i].value, directed_rows[i].pos,
				directed_rows[i].has_known, directed_rows[i].known);
		end

		// Random traffic swings between growing toward full and draining to
		// empty, so both ends of the list and long listings come up often.
		growing = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet_stretch = (n >= 90 && n < 140);
			count = stored_values.size();
			if (count >= LIST_CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
			if (count == 0 && $urandom_range(2) == 0) growing = 1'b1;
			roll = $urandom_range(99);
			if (roll < (growing ? 60 : 20)) begin
				case ($urandom_range(2))
					0: md = MODE_INS_FRONT;
					1: md = MODE_INS_END;
					default: md = MODE_INS_POS;
				endcase
				p = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
					: 6'($urandom_range(count + 1, 1));
			end else if (roll < (growing ? 75 : 80)) begin
				case ($urandom_range(2))
					0: md = MODE_DEL_FRONT;
					1: md = MODE_DEL_END;
					default: md = MODE_DEL_POS;
				endcase
				p = ($urandom_range(9) == 0 || count == 0) ? 6'($urandom_range(63))
					: 6'($urandom_range(count, 1));
			end else if (roll < 92) begin
				md = MODE_LIST;
				p = 6'($urandom_range(63));
			end else if (roll < 96) begin
				md = MODE_UNUSED;
				p = 6'($urandom_range(63));
			end else begin
				// Out-of-range position on a positional request.
				md = $urandom_range(1) ? MODE_INS_POS : MODE_DEL_POS;
				p = $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, count + 2));
			end
			send_request(md, pick_value(), p, 1'b0, NO_RESULT);
		end
		quiet_stretch = 1'b0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// Drain, then give the block a walk's worth of cycles to show stray items.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LIST_CAPACITY + 20) @(posedge clk);
		if (pending_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		end

		if (error_count == 0) begin
			$display("positional_list_store_tb: clean");
		end else begin
			$display("positional_list_store_tb: errors");
		end
		$finish;
	end

endmodule
